// ===== rtl/ccs_pkg.sv =====
// Shared types, mode and command codes, and the month day-limit function.
package ccs_pkg;

  // Mode codes
  localparam logic [2:0] MODE_MENU      = 3'd0;
  localparam logic [2:0] MODE_TIME_SHOW = 3'd1;
  localparam logic [2:0] MODE_TIME_EDIT = 3'd2;
  localparam logic [2:0] MODE_DATE_SHOW = 3'd3;
  localparam logic [2:0] MODE_DATE_EDIT = 3'd4;
  localparam logic [2:0] MODE_STOPWATCH = 3'd5;

  // Command digit codes (byte minus ASCII '0')
  localparam logic [2:0] CMD_MENU = 3'd0;
  localparam logic [2:0] CMD_ONE  = 3'd1;
  localparam logic [2:0] CMD_TWO  = 3'd2;
  localparam logic [2:0] CMD_THREE = 3'd3;
  localparam logic [2:0] CMD_FOUR = 3'd4;
  localparam logic [2:0] CMD_FIVE = 3'd5;
  localparam logic [2:0] CMD_SIX  = 3'd6;

  localparam logic [7:0] ASCII_ZERO = 8'd48;
  localparam logic [7:0] ASCII_SIX  = 8'd54;

  // Reset values
  localparam logic [3:0]  RST_HOUR  = 4'd2;
  localparam logic [4:0]  RST_DAY   = 5'd17;
  localparam logic [3:0]  RST_MONTH = 4'd4;
  localparam logic [15:0] RST_YEAR  = 16'd2024;

  typedef struct packed {
    logic [2:0]  mode;
    logic [3:0]  hours;
    logic [5:0]  minutes;
    logic [5:0]  seconds;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [15:0] year;
    logic [7:0]  sw_minutes;
    logic [5:0]  sw_seconds;
    logic        sw_running;
  } ccs_state_t;

  // Last valid day of a month: Feb 29, long months 31, others 30
  function automatic logic [4:0] day_limit(input logic [3:0] m);
    logic [4:0] lim;
    case (m)
      4'd2:  lim = 5'd29;
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: lim = 5'd31;
      default: lim = 5'd30;
    endcase
    return lim;
  endfunction

endpackage

// ===== rtl/ccs_update.sv =====
// Next-state logic: tick rollover, menu selection, time/date edit, stopwatch commands.
module ccs_update (
  input  ccs_pkg::ccs_state_t cur,
  input  logic                is_command,
  input  logic [7:0]          command_byte,
  output ccs_pkg::ccs_state_t nxt
);
  import ccs_pkg::*;

  logic       cmd_ok;
  logic [2:0] cmd;
  logic [4:0] lim;
  logic [7:0] cmd_off;

  assign cmd_ok  = (command_byte >= ASCII_ZERO) && (command_byte <= ASCII_SIX);
  assign cmd_off = command_byte - ASCII_ZERO;
  assign cmd     = cmd_off[2:0];
  assign lim     = day_limit(cur.month);

  always_comb begin
    nxt = cur;
    if (!is_command) begin
      // one-second tick: clock always, stopwatch when running
      if (cur.seconds >= 6'd59) begin
        nxt.seconds = '0;
        if (cur.minutes >= 6'd59) begin
          nxt.minutes = '0;
          nxt.hours   = (cur.hours >= 4'd12) ? 4'd1 : cur.hours + 4'd1;
        end else begin
          nxt.minutes = cur.minutes + 6'd1;
        end
      end else begin
        nxt.seconds = cur.seconds + 6'd1;
      end
      if (cur.sw_running) begin
        if (cur.sw_seconds >= 6'd59) begin
          nxt.sw_seconds = '0;
          nxt.sw_minutes = cur.sw_minutes + 8'd1;
        end else begin
          nxt.sw_seconds = cur.sw_seconds + 6'd1;
        end
      end
    end else if (cmd_ok) begin
      if (cmd == CMD_MENU) begin
        nxt.mode = MODE_MENU;
      end else begin
        case (cur.mode)
          MODE_TIME_SHOW, MODE_DATE_SHOW: begin
          end
          MODE_TIME_EDIT: begin
            case (cmd)
              CMD_ONE:   nxt.hours = (cur.hours >= 4'd12) ? 4'd1 : cur.hours + 4'd1;
              CMD_TWO:   nxt.hours = (cur.hours <= 4'd1) ? 4'd12 : cur.hours - 4'd1;
              CMD_THREE: nxt.minutes = (cur.minutes >= 6'd59) ? 6'd0 : cur.minutes + 6'd1;
              CMD_FOUR:  nxt.minutes = (cur.minutes == 6'd0) ? 6'd59 : cur.minutes - 6'd1;
              default: ;
            endcase
          end
          MODE_DATE_EDIT: begin
            case (cmd)
              CMD_ONE:   nxt.day = (cur.day >= lim) ? 5'd1 : cur.day + 5'd1;
              CMD_TWO:   nxt.day = (cur.day <= 5'd1) ? lim : cur.day - 5'd1;
              CMD_THREE: nxt.month = (cur.month >= 4'd12) ? 4'd1 : cur.month + 4'd1;
              CMD_FOUR:  nxt.month = (cur.month <= 4'd1) ? 4'd12 : cur.month - 4'd1;
              CMD_FIVE:  nxt.year = cur.year + 16'd1;
              CMD_SIX:   nxt.year = cur.year - 16'd1;
              default: ;
            endcase
          end
          MODE_STOPWATCH: begin
            case (cmd)
              CMD_ONE: nxt.sw_running = 1'b1;
              CMD_TWO: nxt.sw_running = 1'b0;
              CMD_THREE: begin
                nxt.sw_running = 1'b0;
                nxt.sw_seconds = '0;
                nxt.sw_minutes = '0;
              end
              default: ;
            endcase
          end
          default: begin
            // menu (and unused codes): digits 1..5 pick a mode
            if (cmd <= CMD_FIVE) nxt.mode = cmd;
          end
        endcase
      end
    end
  end

endmodule

// ===== rtl/clock_calendar_stopwatch_controller.sv =====
// Top level: input register, state/result register, and output handshake.
// An item passes through the input register, then the state register that drives the outputs.
// Throughput: one item per cycle while the result is not stalled; the state register doubles as the result register.
// The next state comes from one pass through the update logic in ccs_update.
// Reset (synchronous, rst high): menu mode, 02:00:00, day 17 month 4 year 2024,
// stopwatch 00:00 stopped, both channels empty.
module clock_calendar_stopwatch_controller (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        is_command,
  input  logic [7:0]  command_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  mode,
  output logic [3:0]  hours,
  output logic [5:0]  minutes,
  output logic [5:0]  seconds,
  output logic [4:0]  day,
  output logic [3:0]  month,
  output logic [15:0] year,
  output logic [7:0]  sw_minutes,
  output logic [5:0]  sw_seconds,
  output logic        sw_running
);
  import ccs_pkg::*;

  logic       in_full;
  logic       in_cmd;
  logic [7:0] in_byte;
  logic       advance;
  ccs_state_t state;
  ccs_state_t state_next;

  // Item moves into the state when the result slot is free or being drained
  assign advance  = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
    if (in_valid && in_ready) begin
      in_cmd  <= is_command;
      in_byte <= command_byte;
    end
  end

  ccs_update u_update (
    .cur          (state),
    .is_command   (in_cmd),
    .command_byte (in_byte),
    .nxt          (state_next)
  );

  // State register, which is also the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state.mode       <= MODE_MENU;
      state.hours      <= RST_HOUR;
      state.minutes    <= '0;
      state.seconds    <= '0;
      state.day        <= RST_DAY;
      state.month      <= RST_MONTH;
      state.year       <= RST_YEAR;
      state.sw_minutes <= '0;
      state.sw_seconds <= '0;
      state.sw_running <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      if (advance) begin
        state <= state_next;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign mode       = state.mode;
  assign hours      = state.hours;
  assign minutes    = state.minutes;
  assign seconds    = state.seconds;
  assign day        = state.day;
  assign month      = state.month;
  assign year       = state.year;
  assign sw_minutes = state.sw_minutes;
  assign sw_seconds = state.sw_seconds;
  assign sw_running = state.sw_running;

`ifndef ASSERT_OFF
  // Mode never leaves the defined set
  a_mode_range: assert property (@(posedge clk) disable iff (rst)
    state.mode <= MODE_STOPWATCH)
    else $error("mode out of range");

  // Hours stay on the twelve-hour dial
  a_hour_range: assert property (@(posedge clk) disable iff (rst)
    (state.hours >= 4'd1) && (state.hours <= 4'd12))
    else $error("hours out of range");

  // A held result keeps the state frozen
  a_hold_state: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(state))
    else $error("state changed while result stalled");

  // Stopwatch counts only while running
  a_sw_stopped: assert property (@(posedge clk) disable iff (rst)
    advance && !in_cmd && !state.sw_running |=>
      $stable(state.sw_seconds) && $stable(state.sw_minutes))
    else $error("stopwatch moved while stopped");
`endif

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the clock, calendar and stopwatch controller.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ccs_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned MAX_REPORTS  = 40;
  // one bit per month number that has 31 days
  localparam logic [15:0] LONG_MONTHS  = 16'h15AA;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic        is_command;
  logic [7:0]  command_byte;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  mode;
  logic [3:0]  hours;
  logic [5:0]  minutes;
  logic [5:0]  seconds;
  logic [4:0]  day;
  logic [3:0]  month;
  logic [15:0] year;
  logic [7:0]  sw_minutes;
  logic [5:0]  sw_seconds;
  logic        sw_running;

  ccs_state_t  tracked_clock;
  ccs_state_t  awaited_states[$];
  ccs_state_t  want;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned cycle_count    = 0;
  int          items_sent     = 0;
  int          error_count    = 0;

  clock_calendar_stopwatch_controller DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .is_command   (is_command),
    .command_byte (command_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .mode         (mode),
    .hours        (hours),
    .minutes      (minutes),
    .seconds      (seconds),
    .day          (day),
    .month        (month),
    .year         (year),
    .sw_minutes   (sw_minutes),
    .sw_seconds   (sw_seconds),
    .sw_running   (sw_running)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t ns: timeout, %0d results still awaited", $time, awaited_states.size());
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // Result side back-pressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99, 0) >= recv_stall_pct);
  end

  // Days in a month; February is fixed at 29
  function automatic logic [4:0] month_length(input logic [3:0] m);
    if (m == 4'd2) return 5'd29;
    return LONG_MONTHS[m] ? 5'd31 : 5'd30;
  endfunction

  // State after one tick or one command byte
  function automatic ccs_state_t next_clock_state(input ccs_state_t s, input logic cmd,
                                                  input logic [7:0] b);
    ccs_state_t n;
    logic [7:0] offs;
    logic [2:0] digit;
    logic [4:0] lim;
    n     = s;
    offs  = b - ASCII_ZERO;
    digit = offs[2:0];
    lim   = month_length(s.month);
    if (!cmd) begin
      // time of day, hours wrap 12 -> 1
      if (s.seconds >= 6'd59) begin
        n.seconds = '0;
        if (s.minutes >= 6'd59) begin
          n.minutes = '0;
          n.hours   = (s.hours >= 4'd12) ? 4'd1 : s.hours + 4'd1;
        end else begin
          n.minutes = s.minutes + 6'd1;
        end
      end else begin
        n.seconds = s.seconds + 6'd1;
      end
      // stopwatch counts in any mode
      if (s.sw_running) begin
        if (s.sw_seconds >= 6'd59) begin
          n.sw_seconds = '0;
          n.sw_minutes = s.sw_minutes + 8'd1;
        end else begin
          n.sw_seconds = s.sw_seconds + 6'd1;
        end
      end
    end else if (b >= ASCII_ZERO && b <= ASCII_SIX) begin
      if (digit == CMD_MENU) begin
        n.mode = MODE_MENU;
      end else begin
        case (s.mode)
          MODE_TIME_SHOW, MODE_DATE_SHOW: begin
          end
          MODE_TIME_EDIT: begin
            case (digit)
              CMD_ONE:   n.hours = (s.hours >= 4'd12) ? 4'd1 : s.hours + 4'd1;
              CMD_TWO:   n.hours = (s.hours <= 4'd1) ? 4'd12 : s.hours - 4'd1;
              CMD_THREE: n.minutes = (s.minutes >= 6'd59) ? 6'd0 : s.minutes + 6'd1;
              CMD_FOUR:  n.minutes = (s.minutes == 6'd0) ? 6'd59 : s.minutes - 6'd1;
              default: ;
            endcase
          end
          MODE_DATE_EDIT: begin
            case (digit)
              CMD_ONE:   n.day = (s.day >= lim) ? 5'd1 : s.day + 5'd1;
              CMD_TWO:   n.day = (s.day <= 5'd1) ? lim : s.day - 5'd1;
              CMD_THREE: n.month = (s.month >= 4'd12) ? 4'd1 : s.month + 4'd1;
              CMD_FOUR:  n.month = (s.month <= 4'd1) ? 4'd12 : s.month - 4'd1;
              CMD_FIVE:  n.year = s.year + 16'd1;
              CMD_SIX:   n.year = s.year - 16'd1;
              default: ;
            endcase
          end
          MODE_STOPWATCH: begin
            case (digit)
              CMD_ONE: n.sw_running = 1'b1;
              CMD_TWO: n.sw_running = 1'b0;
              CMD_THREE: begin
                n.sw_running = 1'b0;
                n.sw_seconds = '0;
                n.sw_minutes = '0;
              end
              default: ;
            endcase
          end
          // menu, and any stray code treated as menu
          default: begin
            if (digit <= CMD_FIVE) n.mode = digit;
          end
        endcase
      end
    end
    return n;
  endfunction

  function automatic logic [7:0] key(input logic [2:0] d);
    return ASCII_ZERO + {5'd0, d};
  endfunction

  task automatic check_field(input string name, input logic [15:0] exp_val,
                             input logic [15:0] got_val);
    if (got_val !== exp_val) begin
      error_count++;
      if (error_count <= MAX_REPORTS)
        $display("%0t ns: %s expected %0d, got %0d", $time, name, exp_val, got_val);
    end
  endtask

  // Result checker: values at the falling edge are what the next rising edge transfers
  always @(negedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (awaited_states.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("%0t ns: result with none expected, got mode %0d %0d:%0d:%0d", $time,
                   mode, hours, minutes, seconds);
      end else begin
        want = awaited_states.pop_front();
        check_field("mode", 16'(want.mode), 16'(mode));
        check_field("hours", 16'(want.hours), 16'(hours));
        check_field("minutes", 16'(want.minutes), 16'(minutes));
        check_field("seconds", 16'(want.seconds), 16'(seconds));
        check_field("day", 16'(want.day), 16'(day));
        check_field("month", 16'(want.month), 16'(month));
        check_field("year", want.year, year);
        check_field("sw_minutes", 16'(want.sw_minutes), 16'(sw_minutes));
        check_field("sw_seconds", 16'(want.sw_seconds), 16'(sw_seconds));
        check_field("sw_running", 16'(want.sw_running), 16'(sw_running));
      end
    end
  end

  // One input transfer, with random idle cycles ahead of it
  task automatic send_item(input logic cmd, input logic [7:0] b);
    logic taken;
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid     <= 1'b0;
      is_command   <= ($urandom_range(1, 0) == 1);
      command_byte <= 8'($urandom_range(255, 0));
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    is_command   <= cmd;
    command_byte <= b;
    taken = 1'b0;
    while (taken !== 1'b1) begin
      @(negedge clk);
      taken = in_ready;
      @(posedge clk);
    end
    tracked_clock = next_clock_state(tracked_clock, cmd, b);
    awaited_states.push_back(tracked_clock);
    items_sent++;
  endtask

  task automatic send_key(input logic [2:0] d);
    send_item(1'b1, key(d));
  endtask

  task automatic send_tick();
    send_item(1'b0, 8'($urandom_range(255, 0)));
  endtask

  task automatic tick_burst(input int n);
    repeat (n) send_tick();
  endtask

  task automatic steer_month(input logic [3:0] target);
    while (tracked_clock.month != target) send_key(CMD_THREE);
  endtask

  // target must not exceed the current month's limit
  task automatic steer_day(input logic [4:0] target);
    while (tracked_clock.day != target)
      send_key((tracked_clock.day < target) ? CMD_ONE : CMD_TWO);
  endtask

  // Field extremes, ignored bytes and every command of every mode
  task automatic test_directed();
    send_item(1'b0, 8'hFF);
    send_item(1'b1, 8'h00);
    send_item(1'b1, 8'hFF);
    send_item(1'b1, ASCII_ZERO - 8'd1);
    send_item(1'b1, ASCII_SIX + 8'd1);
    send_key(CMD_MENU);
    send_key(CMD_SIX);
    send_key(MODE_TIME_SHOW);
    send_key(CMD_THREE);
    send_key(CMD_MENU);
    send_key(MODE_TIME_EDIT);
    send_key(CMD_ONE);
    send_key(CMD_TWO);
    send_key(CMD_FOUR);
    send_key(CMD_THREE);
    send_key(CMD_MENU);
    send_key(MODE_DATE_SHOW);
    send_key(CMD_FIVE);
    send_key(CMD_MENU);
    send_key(MODE_DATE_EDIT);
    send_key(CMD_FIVE);
    send_key(CMD_SIX);
    send_key(CMD_THREE);
    send_key(CMD_FOUR);
    send_key(CMD_ONE);
    send_key(CMD_TWO);
    send_key(CMD_MENU);
    send_key(MODE_STOPWATCH);
    send_key(CMD_ONE);
    send_tick();
    send_key(CMD_TWO);
    send_key(CMD_THREE);
    send_key(CMD_MENU);
  endtask

  // Hour edit wraps both ways, then ticks carry 12:59:xx over to 1:00
  task automatic test_hour_rollover();
    send_key(CMD_MENU);
    send_key(MODE_TIME_EDIT);
    while (tracked_clock.hours != 4'd12) send_key(CMD_ONE);
    send_key(CMD_ONE);
    send_key(CMD_TWO);
    while (tracked_clock.minutes != 6'd59)
      send_key((tracked_clock.minutes < 6'd30) ? CMD_FOUR : CMD_THREE);
    while (tracked_clock.hours != 4'd1) send_tick();
    send_key(CMD_MENU);
  endtask

  // Day wraps at each kind of month limit, and a day left above a shorter limit
  task automatic test_calendar();
    logic [4:0] want_lim;
    logic [3:0] target;
    send_key(CMD_MENU);
    send_key(MODE_DATE_EDIT);
    for (int k = 0; k < 3; k++) begin
      want_lim = (k == 0) ? 5'd29 : (k == 1) ? 5'd31 : 5'd30;
      do target = 4'($urandom_range(12, 1)); while (month_length(target) != want_lim);
      steer_month(target);
      steer_day(want_lim);
      send_key(CMD_ONE);
      send_key(CMD_TWO);
    end
    // month change keeps day 31 in February
    steer_month(4'd1);
    steer_day(5'd31);
    send_key(CMD_THREE);
    send_key(CMD_TWO);
    send_key(CMD_ONE);
    steer_month(4'd1);
    send_key(CMD_FOUR);
    send_key(CMD_FIVE);
    send_key(CMD_FIVE);
    send_key(CMD_SIX);
    send_key(CMD_SIX);
    send_key(CMD_SIX);
    send_key(CMD_MENU);
  endtask

  // Stopwatch carries, pause, clear while running, counting outside its mode
  task automatic test_stopwatch();
    send_key(CMD_MENU);
    send_key(MODE_STOPWATCH);
    send_key(CMD_THREE);
    send_key(CMD_ONE);
    tick_burst(125);
    send_key(CMD_TWO);
    tick_burst(3);
    send_key(CMD_ONE);
    tick_burst(2);
    send_key(CMD_THREE);
    send_tick();
    send_key(CMD_ONE);
    send_key(CMD_MENU);
    tick_burst(5);
    send_key(MODE_STOPWATCH);
    send_key(CMD_TWO);
    send_key(CMD_MENU);
  endtask

  // Enter a mode from the menu and press random keys; top is the highest useful digit
  task automatic mode_session(input logic [2:0] m, input int top);
    int r;
    send_key(CMD_MENU);
    send_key(m);
    repeat ($urandom_range(12, 1)) begin
      r = $urandom_range(99, 0);
      if (r < 10) send_tick();
      else if (r < 18) send_item(1'b1, 8'($urandom_range(255, 0)));
      else send_key(3'($urandom_range(top, 1)));
    end
    if ($urandom_range(3, 0) != 0) send_key(CMD_MENU);
  endtask

  task automatic stopwatch_session();
    send_key(CMD_MENU);
    send_key(MODE_STOPWATCH);
    repeat ($urandom_range(6, 1)) begin
      if ($urandom_range(9, 0) == 0) send_key(3'($urandom_range(6, 4)));
      else send_key(3'($urandom_range(3, 1)));
      tick_burst(($urandom_range(7, 0) == 0) ? $urandom_range(70, 50) : $urandom_range(8, 0));
    end
    if ($urandom_range(3, 0) != 0) send_key(CMD_MENU);
  endtask

  // Stray items in whatever mode the block is in
  task automatic noise_burst(input int n);
    repeat (n) begin
      if ($urandom_range(1, 0) == 1)
        send_item($urandom_range(1, 0) == 1, 8'($urandom_range(255, 0)));
      else
        send_item($urandom_range(1, 0) == 1, key(3'($urandom_range(6, 0))));
    end
  endtask

  // Mostly well-formed menu sessions with random content
  task automatic test_random_sessions(input int n);
    int stop_at;
    int pick;
    stop_at = items_sent + n;
    while (items_sent < stop_at) begin
      pick = $urandom_range(99, 0);
      if (pick < 20)
        tick_burst(($urandom_range(4, 0) == 0) ? $urandom_range(70, 40) : $urandom_range(12, 1));
      else if (pick < 40) mode_session(MODE_TIME_EDIT, 4);
      else if (pick < 60) mode_session(MODE_DATE_EDIT, 6);
      else if (pick < 75) stopwatch_session();
      else if (pick < 80) mode_session(MODE_TIME_SHOW, 6);
      else if (pick < 85) mode_session(MODE_DATE_SHOW, 6);
      else noise_burst($urandom_range(8, 1));
    end
  endtask

  initial begin
    rst          <= 1'b1;
    in_valid     <= 1'b0;
    is_command   <= 1'b0;
    command_byte <= 8'd0;
    out_ready    <= 1'b0;
    tracked_clock.mode       = MODE_MENU;
    tracked_clock.hours      = RST_HOUR;
    tracked_clock.minutes    = '0;
    tracked_clock.seconds    = '0;
    tracked_clock.day        = RST_DAY;
    tracked_clock.month      = RST_MONTH;
    tracked_clock.year       = RST_YEAR;
    tracked_clock.sw_minutes = '0;
    tracked_clock.sw_seconds = '0;
    tracked_clock.sw_running = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // back to back, no idling
    test_directed();
    test_hour_rollover();
    // sender idles often
    send_idle_pct = 63;
    test_calendar();
    test_random_sessions(150);
    // receiver stalls often
    send_idle_pct  = 0;
    recv_stall_pct = 63;
    test_stopwatch();
    test_random_sessions(150);
    // both sides idle now and then
    send_idle_pct  = 27;
    recv_stall_pct = 27;
    test_random_sessions(200);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_random_sessions(60);

    // drain outstanding results, then watch for strays
    in_valid <= 1'b0;
    while (awaited_states.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/ccs_pkg.sv
rtl/ccs_update.sv
rtl/clock_calendar_stopwatch_controller.sv
tb/tb_top.sv
